@@ hdl/itc_pkg.sv @@
// Shared types and constants for the iron temperature conditioner.
package itc_pkg;

    // Linearization breakpoints (ADC codes) and the temperature at code zero
    localparam int SEG_A    = 1212;
    localparam int SEG_B    = 1696;
    localparam int SEG_C    = 2181;
    localparam int COLD_DEG = 21;

    // Divisor width: the widest segment span is below 2^11
    localparam int DEN_W = 11;
    // Magnitude width of a temperature difference
    localparam int DY_W  = 10;

    localparam logic [10:0] PWM_OFF    = 11'd1999;
    localparam logic [10:0] HEAT_LIMIT = 11'd180;
    localparam logic [9:0]  ERR_LIMIT  = 10'd500;
    localparam logic [9:0]  TEMP_MAX   = 10'd1023;

    // Configuration register indexes
    localparam logic [2:0] CFG_SET_TEMP   = 3'd0;
    localparam logic [2:0] CFG_SLEEP_TEMP = 3'd1;
    localparam logic [2:0] CFG_BOOST_TEMP = 3'd2;
    localparam logic [2:0] CFG_CAL_LOW    = 3'd3;
    localparam logic [2:0] CFG_CAL_MID    = 3'd4;
    localparam logic [2:0] CFG_CAL_HIGH   = 3'd5;
    localparam logic [2:0] CFG_SHIFT      = 3'd6;
    localparam logic [2:0] CFG_BEEP_EN    = 3'd7;

    // Status codes
    localparam logic [2:0] STS_ERROR   = 3'd0;
    localparam logic [2:0] STS_OFF     = 3'd1;
    localparam logic [2:0] STS_SLEEP   = 3'd2;
    localparam logic [2:0] STS_BOOST   = 3'd3;
    localparam logic [2:0] STS_WORKING = 3'd4;
    localparam logic [2:0] STS_HEATING = 3'd5;
    localparam logic [2:0] STS_HOLDING = 3'd6;

    typedef struct packed {
        logic [8:0] set_temp;
        logic [8:0] sleep_temp;
        logic [7:0] boost_temp;
        logic [9:0] cal_low;
        logic [9:0] cal_mid;
        logic [9:0] cal_high;
        logic [2:0] smooth_shift;
        logic       beep_on;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_FILT,
        S_SEG,
        S_MUL,
        S_RCP,
        S_CUR,
        S_FIN
    } t_state;

    typedef struct packed {
        logic load_in;   // capture the input item
        logic filt;      // update the smoothing filter
        logic seg;       // pick the segment, register operands
        logic mul;       // multiply dx by dy magnitude
        logic rcp_mul;   // scale by the segment reciprocal
        logic cur;       // sign, offset and saturate
        logic commit;    // update state and load the output register
    } t_cmd;

    typedef struct packed {
        logic out_free;  // output register can take a result this cycle
    } t_sts;

endpackage

@@ hdl/itc_cfg.sv @@
// Configuration register bank for the iron temperature conditioner.
module itc_cfg (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic [2:0]      i_cfg_index,
    input  logic [9:0]      i_cfg_data,
    output itc_pkg::t_cfg   o_cfg
);

    itc_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_temp     <= 9'd320;
            r_cfg.sleep_temp   <= 9'd150;
            r_cfg.boost_temp   <= 8'd50;
            r_cfg.cal_low      <= 10'd200;
            r_cfg.cal_mid      <= 10'd280;
            r_cfg.cal_high     <= 10'd360;
            r_cfg.smooth_shift <= 3'd4;
            r_cfg.beep_on      <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                itc_pkg::CFG_SET_TEMP:   r_cfg.set_temp     <= i_cfg_data[8:0];
                itc_pkg::CFG_SLEEP_TEMP: r_cfg.sleep_temp   <= i_cfg_data[8:0];
                itc_pkg::CFG_BOOST_TEMP: r_cfg.boost_temp   <= i_cfg_data[7:0];
                itc_pkg::CFG_CAL_LOW:    r_cfg.cal_low      <= i_cfg_data;
                itc_pkg::CFG_CAL_MID:    r_cfg.cal_mid      <= i_cfg_data;
                itc_pkg::CFG_CAL_HIGH:   r_cfg.cal_high     <= i_cfg_data;
                itc_pkg::CFG_SHIFT:      r_cfg.smooth_shift <= i_cfg_data[2:0];
                itc_pkg::CFG_BEEP_EN:    r_cfg.beep_on      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ hdl/itc_ctrl.sv @@
// Sequencing state machine for the iron temperature conditioner.
module itc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  itc_pkg::t_sts   i_sts,
    output itc_pkg::t_cmd   o_cmd
);

    itc_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= itc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            itc_pkg::S_IDLE: begin
                if (i_valid) n_state = itc_pkg::S_FILT;
            end
            itc_pkg::S_FILT: n_state = itc_pkg::S_SEG;
            itc_pkg::S_SEG:  n_state = itc_pkg::S_MUL;
            itc_pkg::S_MUL:  n_state = itc_pkg::S_RCP;
            itc_pkg::S_RCP:  n_state = itc_pkg::S_CUR;
            itc_pkg::S_CUR:  n_state = itc_pkg::S_FIN;
            itc_pkg::S_FIN: begin
                if (i_sts.out_free) n_state = itc_pkg::S_IDLE;
            end
            default: n_state = itc_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            itc_pkg::S_IDLE: begin
                o_ready       = 1'b1;
                o_cmd.load_in = i_valid;
            end
            itc_pkg::S_FILT: o_cmd.filt    = 1'b1;
            itc_pkg::S_SEG:  o_cmd.seg     = 1'b1;
            itc_pkg::S_MUL:  o_cmd.mul     = 1'b1;
            itc_pkg::S_RCP:  o_cmd.rcp_mul = 1'b1;
            itc_pkg::S_CUR:  o_cmd.cur     = 1'b1;
            itc_pkg::S_FIN:  o_cmd.commit  = i_sts.out_free;
            default: ;
        endcase
    end

endmodule

@@ hdl/itc_dp.sv @@
// Datapath: filter, segment interpolation by reciprocal multiply, mode logic.
module itc_dp #(
    parameter int ADC_BITS  = 12,
    parameter int FRAC_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  itc_pkg::t_cmd       i_cmd,
    output itc_pkg::t_sts       o_sts,
    input  itc_pkg::t_cfg       i_cfg,
    input  logic [ADC_BITS-1:0] i_adc_code,
    input  logic                i_off_mode,
    input  logic                i_sleep_mode,
    input  logic                i_boost_mode,
    input  logic                i_ready,
    output logic                o_valid,
    output logic [9:0]          o_current_temp,
    output logic [9:0]          o_shown_temp,
    output logic [9:0]          o_target_temp,
    output logic [10:0]         o_heater_compare,
    output logic                o_working,
    output logic                o_beep_pulse,
    output logic [2:0]          o_status
);

    localparam int FW    = ADC_BITS + FRAC_BITS;
    localparam int MW    = ADC_BITS + itc_pkg::DY_W;
    localparam int DEN_W = itc_pkg::DEN_W;
    localparam int XW    = 17;  // holds any raw code and every breakpoint
    // Reciprocal ceil(2^KSH / span): exact floor quotient for any MW-bit product,
    // since the rounding excess stays below the span, which is below 2^DEN_W.
    localparam int KSH   = MW + DEN_W;
    localparam int RW    = KSH - 8;   // every span exceeds 2^8
    localparam int PW    = MW + RW;
    localparam int QW    = PW - KSH;
    localparam longint ONE_K   = longint'(1) << KSH;
    localparam longint SPAN_0A = longint'(itc_pkg::SEG_A);
    localparam longint SPAN_AB = longint'(itc_pkg::SEG_B - itc_pkg::SEG_A);
    localparam longint SPAN_BC = longint'(itc_pkg::SEG_C - itc_pkg::SEG_B);
    localparam logic [RW-1:0] RCP_0A = RW'((ONE_K + SPAN_0A - 1) / SPAN_0A);
    localparam logic [RW-1:0] RCP_AB = RW'((ONE_K + SPAN_AB - 1) / SPAN_AB);
    localparam logic [RW-1:0] RCP_BC = RW'((ONE_K + SPAN_BC - 1) / SPAN_BC);

    // input item
    logic [ADC_BITS-1:0] r_code;
    logic                r_off, r_sleep, r_boost;

    // persistent state
    logic [FW-1:0] r_filt;
    logic          r_loaded;
    logic [9:0]    r_disp;
    logic [9:0]    r_prev_tgt;
    logic          r_in_range;
    logic          r_armed;

    // operands and products
    logic [ADC_BITS-1:0]  r_dx;
    logic [9:0]           r_dy_mag;
    logic                 r_neg;
    logic [9:0]           r_y0;
    logic [RW-1:0]        r_rcp;
    logic [MW-1:0]        r_prod;
    logic [PW-1:0]        r_scaled;
    logic [9:0]           r_cur;

    // output register
    logic        r_out_valid;
    logic [9:0]  r_o_cur, r_o_shown, r_o_tgt;
    logic [10:0] r_o_cmp;
    logic        r_o_work, r_o_beep;
    logic [2:0]  r_o_sts;

    // ---------------- filter
    logic [FW-1:0]      sample;
    logic signed [FW:0] diff, step, filt_sum;

    always_comb begin
        sample   = {r_code, {FRAC_BITS{1'b0}}};
        diff     = $signed({1'b0, sample}) - $signed({1'b0, r_filt});
        step     = diff >>> i_cfg.smooth_shift;
        filt_sum = $signed({1'b0, r_filt}) + step;
    end

    // ---------------- segment select
    logic [XW-1:0]       raw_x, x0;
    logic [9:0]          y0, y1;
    logic [RW-1:0]       rcp;
    logic signed [10:0]  dy;
    logic [XW-1:0]       dx_full;

    always_comb begin
        raw_x = XW'(r_filt[FW-1:FRAC_BITS]);
        if (raw_x < XW'(itc_pkg::SEG_A)) begin
            x0  = '0;
            y0  = 10'(itc_pkg::COLD_DEG);
            y1  = i_cfg.cal_low;
            rcp = RCP_0A;
        end else if (raw_x < XW'(itc_pkg::SEG_B)) begin
            x0  = XW'(itc_pkg::SEG_A);
            y0  = i_cfg.cal_low;
            y1  = i_cfg.cal_mid;
            rcp = RCP_AB;
        end else begin
            x0  = XW'(itc_pkg::SEG_B);
            y0  = i_cfg.cal_mid;
            y1  = i_cfg.cal_high;
            rcp = RCP_BC;
        end
        dx_full = raw_x - x0;
        dy      = $signed({1'b0, y1}) - $signed({1'b0, y0});
    end

    // ---------------- sign, offset, saturation
    logic [QW-1:0]        q_mag;
    logic signed [MW+1:0] q_s, cur_sum;
    logic [9:0]           cur_sat;

    always_comb begin
        q_mag   = r_scaled[PW-1:KSH];
        q_s     = r_neg ? -$signed((MW + 2)'(q_mag)) : $signed((MW + 2)'(q_mag));
        cur_sum = q_s + $signed((MW + 2)'(r_y0));
        if (cur_sum < 0)
            cur_sat = '0;
        else if (cur_sum > $signed((MW + 2)'(itc_pkg::TEMP_MAX)))
            cur_sat = itc_pkg::TEMP_MAX;
        else
            cur_sat = cur_sum[9:0];
    end

    // ---------------- display, range, mode
    logic [9:0]  disp_a, disp_b, d_dc, d_ap, d_sc, tgt;
    logic        in_rng, pulse;
    logic [10:0] cmp;
    logic [2:0]  sts;

    function automatic logic [9:0] absdiff(input logic [9:0] a, input logic [9:0] b);
        absdiff = (a > b) ? a - b : b - a;
    endfunction

    always_comb begin
        d_dc   = absdiff(r_disp, r_cur);
        disp_a = (r_disp != r_prev_tgt || d_dc > 10'd5) ? r_cur : r_disp;
        d_ap   = absdiff(disp_a, r_prev_tgt);
        disp_b = (d_ap <= 10'd1) ? r_prev_tgt : disp_a;

        d_sc   = absdiff({1'b0, i_cfg.set_temp}, r_cur);
        in_rng = d_sc < 10'd5;
        pulse  = in_rng && !r_in_range && r_armed && i_cfg.beep_on;

        if (r_off)
            tgt = '0;
        else if (r_sleep)
            tgt = {1'b0, i_cfg.sleep_temp};
        else if (r_boost)
            tgt = {1'b0, i_cfg.set_temp} + {2'b00, i_cfg.boost_temp};
        else
            tgt = {1'b0, i_cfg.set_temp};

        cmp = (r_cur < tgt) ? 11'd0 : itc_pkg::PWM_OFF;

        if (disp_b > itc_pkg::ERR_LIMIT)  sts = itc_pkg::STS_ERROR;
        else if (r_off)                   sts = itc_pkg::STS_OFF;
        else if (r_sleep)                 sts = itc_pkg::STS_SLEEP;
        else if (r_boost)                 sts = itc_pkg::STS_BOOST;
        else if (in_rng)                  sts = itc_pkg::STS_WORKING;
        else if (cmp < itc_pkg::HEAT_LIMIT) sts = itc_pkg::STS_HEATING;
        else                              sts = itc_pkg::STS_HOLDING;
    end

    // ---------------- operand and work registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_code  <= i_adc_code;
            r_off   <= i_off_mode;
            r_sleep <= i_sleep_mode;
            r_boost <= i_boost_mode;
        end
        if (i_cmd.seg) begin
            r_dx     <= dx_full[ADC_BITS-1:0];
            r_neg    <= dy[10];
            r_dy_mag <= dy[10] ? 10'(-dy) : dy[9:0];
            r_y0     <= y0;
            r_rcp    <= rcp;
        end
        if (i_cmd.mul) r_prod <= MW'(r_dx) * MW'(r_dy_mag);
        if (i_cmd.rcp_mul) r_scaled <= PW'(r_prod) * PW'(r_rcp);
        if (i_cmd.cur) r_cur <= cur_sat;
    end

    // ---------------- persistent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt     <= '0;
            r_loaded   <= 1'b0;
            r_disp     <= '0;
            r_prev_tgt <= '0;
            r_in_range <= 1'b1;
            r_armed    <= 1'b1;
        end else begin
            if (i_cmd.filt) begin
                r_filt   <= r_loaded ? filt_sum[FW-1:0] : sample;
                r_loaded <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_disp     <= disp_b;
                r_prev_tgt <= tgt;
                r_in_range <= in_rng;
                if (in_rng) r_armed <= 1'b0;
            end
        end
    end

    // ---------------- output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_o_cur   <= r_cur;
            r_o_shown <= disp_b;
            r_o_tgt   <= tgt;
            r_o_cmp   <= cmp;
            r_o_work  <= in_rng;
            r_o_beep  <= pulse;
            r_o_sts   <= sts;
        end
    end

    assign o_sts.out_free  = !r_out_valid || i_ready;
    assign o_valid         = r_out_valid;
    assign o_current_temp  = r_o_cur;
    assign o_shown_temp    = r_o_shown;
    assign o_target_temp   = r_o_tgt;
    assign o_heater_compare = r_o_cmp;
    assign o_working       = r_o_work;
    assign o_beep_pulse    = r_o_beep;
    assign o_status        = r_o_sts;

endmodule

@@ hdl/iron_temperature_conditioner.sv @@
// An accepted item passes through the registered steps filter, segment select,
// product, reciprocal scale and saturate, then commits to the output register;
// a held result stalls the commit step. No new item is taken until the commit.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active low): idle, filter unloaded, display and previous
// setpoint zero, range flag and beep arming set, registers at default values.
module iron_temperature_conditioner #(
    parameter int ADC_BITS  = 12,
    parameter int FRAC_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [ADC_BITS-1:0] i_adc_code,
    input  logic                i_off_mode,
    input  logic                i_sleep_mode,
    input  logic                i_boost_mode,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [9:0]          o_current_temp,
    output logic [9:0]          o_shown_temp,
    output logic [9:0]          o_target_temp,
    output logic [10:0]         o_heater_compare,
    output logic                o_working,
    output logic                o_beep_pulse,
    output logic [2:0]          o_status,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [9:0]          i_cfg_data
);

    itc_pkg::t_cfg cfg;
    itc_pkg::t_cmd cmd;
    itc_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    itc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    itc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    itc_dp #(
        .ADC_BITS  (ADC_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg            (cfg),
        .i_adc_code       (i_adc_code),
        .i_off_mode       (i_off_mode),
        .i_sleep_mode     (i_sleep_mode),
        .i_boost_mode     (i_boost_mode),
        .i_ready          (i_ready),
        .o_valid          (o_valid),
        .o_current_temp   (o_current_temp),
        .o_shown_temp     (o_shown_temp),
        .o_target_temp    (o_target_temp),
        .o_heater_compare (o_heater_compare),
        .o_working        (o_working),
        .o_beep_pulse     (o_beep_pulse),
        .o_status         (o_status)
    );

endmodule

@@ test/itc_checker.sv @@
// Checker for the iron temperature conditioner: predicts each result and compares it.
`timescale 1ns / 1ps
module itc_checker
    import itc_pkg::*;
#(
    parameter int ADC_BITS  = 12,
    parameter int FRAC_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic [ADC_BITS-1:0] i_adc_code,
    input  logic                i_off_mode,
    input  logic                i_sleep_mode,
    input  logic                i_boost_mode,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic [9:0]          i_current_temp,
    input  logic [9:0]          i_shown_temp,
    input  logic [9:0]          i_target_temp,
    input  logic [10:0]         i_heater_compare,
    input  logic                i_working,
    input  logic                i_beep_pulse,
    input  logic [2:0]          i_status,
    input  logic                i_cfg_valid,
    input  logic                i_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [9:0]          i_cfg_data,
    input  logic                i_end,
    output int                  o_pending,
    output int                  o_fail_count
);

    typedef struct packed {
        logic [9:0]  cur_temp;
        logic [9:0]  shown;
        logic [9:0]  target;
        logic [10:0] compare;
        logic        working;
        logic        beep;
        logic [2:0]  status;
    } t_reading;

    t_cfg     regs;
    int       filt;
    logic     filt_loaded;
    int       shown_temp;
    int       last_target;
    logic     in_range;
    logic     beep_armed;
    t_reading readings_due[$];
    int       fails = 0;
    int       results_seen;
    logic     end_seen;

    function automatic int absdiff(int a, int b);
        return (a > b) ? a - b : b - a;
    endfunction

    task automatic report(input string msg);
        if (fails < 40) $display("ERROR at %0t ns: %s", $time, msg);
        fails++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            report($sformatf("result %0d %s: got %0d, expected %0d",
                             results_seen, name, got, want));
    endtask

    task automatic predict_reading(input logic [ADC_BITS-1:0] code, input logic off,
                                   input logic sleep, input logic boost,
                                   output t_reading r);
        int   sample;
        int   diff;
        int   raw;
        int   x0;
        int   x1;
        int   y0;
        int   y1;
        int   num;
        int   cur;
        int   tgt;
        int   set;
        int   cmp;
        logic pulse;
        logic [2:0] sts;
        sample = int'(code) << FRAC_BITS;
        if (!filt_loaded) begin
            filt = sample;
            filt_loaded = 1'b1;
        end else begin
            // arithmetic shift floors toward minus infinity on the way down
            diff = sample - filt;
            filt = filt + (diff >>> regs.smooth_shift);
        end

        raw = filt >>> FRAC_BITS;
        if (raw < SEG_A) begin
            x0 = 0;     x1 = SEG_A; y0 = COLD_DEG;     y1 = regs.cal_low;
        end else if (raw < SEG_B) begin
            x0 = SEG_A; x1 = SEG_B; y0 = regs.cal_low; y1 = regs.cal_mid;
        end else begin
            x0 = SEG_B; x1 = SEG_C; y0 = regs.cal_mid; y1 = regs.cal_high;
        end
        num = (raw - x0) * (y1 - y0);
        cur = num / (x1 - x0) + y0;   // quotient truncates toward zero
        if (cur < 0) cur = 0;
        if (cur > int'(TEMP_MAX)) cur = TEMP_MAX;

        if (shown_temp != last_target || absdiff(shown_temp, cur) > 5)
            shown_temp = cur;
        if (absdiff(shown_temp, last_target) <= 1)
            shown_temp = last_target;

        set = regs.set_temp;
        pulse = 1'b0;
        if (absdiff(set, cur) < 5) begin
            pulse = !in_range && beep_armed && regs.beep_on;
            in_range = 1'b1;
            beep_armed = 1'b0;
        end else begin
            in_range = 1'b0;
        end

        if (off)        tgt = 0;
        else if (sleep) tgt = regs.sleep_temp;
        else if (boost) tgt = set + int'(regs.boost_temp);
        else            tgt = set;

        cmp = (cur < tgt) ? 0 : int'(PWM_OFF);
        last_target = tgt;

        if (shown_temp > int'(ERR_LIMIT))  sts = STS_ERROR;
        else if (off)                      sts = STS_OFF;
        else if (sleep)                    sts = STS_SLEEP;
        else if (boost)                    sts = STS_BOOST;
        else if (in_range)                 sts = STS_WORKING;
        else if (cmp < int'(HEAT_LIMIT))   sts = STS_HEATING;
        else                               sts = STS_HOLDING;

        r.cur_temp = cur[9:0];
        r.shown    = shown_temp[9:0];
        r.target   = tgt[9:0];
        r.compare  = cmp[10:0];
        r.working  = in_range;
        r.beep     = pulse;
        r.status   = sts;
    endtask

    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            regs.set_temp     = 9'd320;
            regs.sleep_temp   = 9'd150;
            regs.boost_temp   = 8'd50;
            regs.cal_low      = 10'd200;
            regs.cal_mid      = 10'd280;
            regs.cal_high     = 10'd360;
            regs.smooth_shift = 3'd4;
            regs.beep_on      = 1'b1;
            filt         = 0;
            filt_loaded  = 1'b0;
            shown_temp   = 0;
            last_target  = 0;
            in_range     = 1'b1;
            beep_armed   = 1'b1;
            results_seen = 0;
            end_seen     = 1'b0;
            readings_due.delete();
        end else begin
            // a result never belongs to an item taken at the same edge
            if (i_out_valid && i_out_ready) begin
                if (readings_due.size() == 0) begin
                    report($sformatf("result %0d arrived with nothing pending", results_seen));
                end else begin
                    want = readings_due.pop_front();
                    check_field("current_temp", i_current_temp, want.cur_temp);
                    check_field("shown_temp", i_shown_temp, want.shown);
                    check_field("target_temp", i_target_temp, want.target);
                    check_field("heater_compare", i_heater_compare, want.compare);
                    check_field("working", i_working, want.working);
                    check_field("beep_pulse", i_beep_pulse, want.beep);
                    check_field("status", i_status, want.status);
                end
                results_seen++;
            end
            if (i_in_valid && i_in_ready) begin
                predict_reading(i_adc_code, i_off_mode, i_sleep_mode, i_boost_mode, want);
                readings_due.push_back(want);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_SET_TEMP:   regs.set_temp     = i_cfg_data[8:0];
                    CFG_SLEEP_TEMP: regs.sleep_temp   = i_cfg_data[8:0];
                    CFG_BOOST_TEMP: regs.boost_temp   = i_cfg_data[7:0];
                    CFG_CAL_LOW:    regs.cal_low      = i_cfg_data;
                    CFG_CAL_MID:    regs.cal_mid      = i_cfg_data;
                    CFG_CAL_HIGH:   regs.cal_high     = i_cfg_data;
                    CFG_SHIFT:      regs.smooth_shift = i_cfg_data[2:0];
                    CFG_BEEP_EN:    regs.beep_on      = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_end && !end_seen) begin
                end_seen = 1'b1;
                if (readings_due.size() != 0)
                    report($sformatf("%0d results never arrived", readings_due.size()));
            end
        end
        o_pending    = readings_due.size();
        o_fail_count = fails;
    end

endmodule

@@ test/tb_top.sv @@
// Testbench top: clock, reset, stimulus and verdict for the iron temperature conditioner.
`timescale 1ns / 1ps
module tb_top;
    import itc_pkg::*;

    localparam int LIMIT       = 300000;
    localparam int HOLD_PHASE  = 3;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 40;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 185;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [11:0] adc_code = '0;
    logic        off_mode = 1'b0;
    logic        sleep_mode = 1'b0;
    logic        boost_mode = 1'b0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [9:0]  cfg_data = '0;
    logic        run_end = 1'b0;

    logic        in_ready;
    logic        out_valid;
    logic        cfg_ready;
    logic [9:0]  current_temp;
    logic [9:0]  shown_temp;
    logic [9:0]  target_temp;
    logic [10:0] heater_compare;
    logic        working;
    logic        beep_pulse;
    logic [2:0]  status;
    int          pending;
    int          fail_count;

    int   cycles = 0;
    int   burst_left = 0;
    logic tx_calm = 1'b0;
    logic rx_calm = 1'b0;
    int   rx_phase = -1;
    int   stall_left = 0;
    int   hold_left = 0;
    logic held = 1'b0;

    // local copy of the registers that steer where the random codes go
    int   set_now = 320;
    int   low_now = 200;
    int   mid_now = 280;
    int   high_now = 360;
    int   center = 1900;
    logic tx_off = 1'b0;
    logic tx_sleep = 1'b0;
    logic tx_boost = 1'b0;

    always #5 i_clk = ~i_clk;

    iron_temperature_conditioner u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (in_valid),
        .o_ready          (in_ready),
        .i_adc_code       (adc_code),
        .i_off_mode       (off_mode),
        .i_sleep_mode     (sleep_mode),
        .i_boost_mode     (boost_mode),
        .o_valid          (out_valid),
        .i_ready          (out_ready),
        .o_current_temp   (current_temp),
        .o_shown_temp     (shown_temp),
        .o_target_temp    (target_temp),
        .o_heater_compare (heater_compare),
        .o_working        (working),
        .o_beep_pulse     (beep_pulse),
        .o_status         (status),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    itc_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_adc_code       (adc_code),
        .i_off_mode       (off_mode),
        .i_sleep_mode     (sleep_mode),
        .i_boost_mode     (boost_mode),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_current_temp   (current_temp),
        .i_shown_temp     (shown_temp),
        .i_target_temp    (target_temp),
        .i_heater_compare (heater_compare),
        .i_working        (working),
        .i_beep_pulse     (beep_pulse),
        .i_status         (status),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_end            (run_end),
        .o_pending        (pending),
        .o_fail_count     (fail_count)
    );

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: short random stalls, one long hold-off in the hold phase.
    always @(negedge i_clk) begin
        if (rx_phase == HOLD_PHASE && !held) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left--;
        end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
            out_ready <= 1'b0;
            stall_left = $urandom_range(0, 7);
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic int clamp_code(int c);
        if (c < 0) return 0;
        if (c > 4095) return 4095;
        return c;
    endfunction

    // rough inverse of the linearization, to steer codes toward set_temp
    function automatic int code_for_temp(int t);
        int x0;
        int x1;
        int y0;
        int y1;
        if (t <= low_now) begin
            x0 = 0;     x1 = SEG_A; y0 = COLD_DEG; y1 = low_now;
        end else if (t <= mid_now) begin
            x0 = SEG_A; x1 = SEG_B; y0 = low_now;  y1 = mid_now;
        end else begin
            x0 = SEG_B; x1 = SEG_C; y0 = mid_now;  y1 = high_now;
        end
        if (y1 == y0) return x0;
        return clamp_code(x0 + (t - y0) * (x1 - x0) / (y1 - y0));
    endfunction

    task automatic send_item(input int code, input logic off, input logic sleep,
                             input logic boost);
        int gap;
        @(negedge i_clk);
        if (burst_left == 0) begin
            gap = tx_calm ? 0 : $urandom_range(0, 12);
            burst_left = $urandom_range(1, 10);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        in_valid   <= 1'b1;
        adc_code   <= code[11:0];
        off_mode   <= off;
        sleep_mode <= sleep;
        boost_mode <= boost;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        burst_left--;
    endtask

    task automatic idle_input();
        @(negedge i_clk);
        in_valid <= 1'b0;
        burst_left = 0;
    endtask

    task automatic wait_results();
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int data);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data[9:0];
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input int set, input int sleep_t, input int boost_t,
                                 input int low, input int mid, input int high,
                                 input int shift, input int beep);
        write_reg(CFG_SET_TEMP, set);
        write_reg(CFG_SLEEP_TEMP, sleep_t);
        write_reg(CFG_BOOST_TEMP, boost_t);
        write_reg(CFG_CAL_LOW, low);
        write_reg(CFG_CAL_MID, mid);
        write_reg(CFG_CAL_HIGH, high);
        write_reg(CFG_SHIFT, shift);
        write_reg(CFG_BEEP_EN, beep);
        set_now  = set;
        low_now  = low;
        mid_now  = mid;
        high_now = high;
        center   = code_for_temp(set);
    endtask

    // Mostly a slow walk of the tip reading with sticky modes, plus noise
    // and codes at the segment breakpoints.
    task automatic send_random_item();
        int r;
        int code;
        int pick;
        r = $urandom_range(0, 9);
        if ($urandom_range(0, 9) == 0) begin
            tx_off   = (r == 0);
            tx_sleep = (r == 1 || r == 2);
            tx_boost = (r == 3 || r == 4);
            if (r == 5) begin
                tx_off   = 1'($urandom_range(0, 1));
                tx_sleep = 1'($urandom_range(0, 1));
                tx_boost = 1'($urandom_range(0, 1));
            end
        end
        r = $urandom_range(0, 99);
        if (r < 3) center = clamp_code(code_for_temp(set_now) + $urandom_range(0, 40) - 20);
        else if (r < 6) center = $urandom_range(0, 4095);
        r = $urandom_range(0, 99);
        if (r < 65) begin
            code = clamp_code(center + $urandom_range(0, 4) - 2);
            center = code;
        end else if (r < 85) begin
            code = $urandom_range(0, 4095);
        end else begin
            pick = $urandom_range(0, 4);
            case (pick)
                0:       code = 0;
                1:       code = SEG_A;
                2:       code = SEG_B;
                3:       code = SEG_C;
                default: code = 4095;
            endcase
            code = clamp_code(code + $urandom_range(0, 2) - 1);
        end
        send_item(code, tx_off, tx_sleep, tx_boost);
    endtask

    initial begin
        int low;
        int mid;
        int high;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // defaults: first sample loads the filter, then smoothing both ways
        send_item(4095, 1'b0, 1'b0, 1'b0);
        send_item(0, 1'b0, 1'b0, 1'b0);
        send_item(1000, 1'b0, 1'b0, 1'b0);
        idle_input();
        wait_results();

        // no smoothing: breakpoints, extremes, working range, every mode
        write_reg(CFG_SHIFT, 0);
        send_item(0, 1'b0, 1'b0, 1'b0);
        send_item(1211, 1'b0, 1'b0, 1'b0);
        send_item(1212, 1'b0, 1'b0, 1'b0);
        send_item(1695, 1'b0, 1'b0, 1'b0);
        send_item(1696, 1'b0, 1'b0, 1'b0);
        send_item(2180, 1'b0, 1'b0, 1'b0);
        send_item(2181, 1'b0, 1'b0, 1'b0);
        send_item(4095, 1'b0, 1'b0, 1'b0);   // display above the error limit
        send_item(1940, 1'b0, 1'b0, 1'b0);   // first entry into range: beep
        send_item(1940, 1'b0, 1'b0, 1'b0);
        send_item(1600, 1'b0, 1'b0, 1'b0);
        send_item(1940, 1'b0, 1'b0, 1'b0);   // re-entry, beep already spent
        send_item(1940, 1'b1, 1'b0, 1'b0);
        send_item(1940, 1'b0, 1'b1, 1'b0);
        send_item(1940, 1'b0, 1'b0, 1'b1);
        send_item(1940, 1'b0, 1'b1, 1'b1);
        send_item(1940, 1'b1, 1'b1, 1'b1);
        send_item(1700, 1'b0, 1'b0, 1'b0);
        send_item(1900, 1'b0, 1'b0, 1'b0);   // below target: heating
        idle_input();
        wait_results();

        for (int p = 0; p < PHASES; p++) begin
            if (p == 0) begin
                apply_setting(500, 500, 255, 1023, 1023, 1023, 7, 1);
            end else if (p == 1) begin
                apply_setting(0, 0, 0, 0, 0, 0, 0, 0);
            end else if (p == PHASES - 1) begin
                // unordered calibration: falling segments, saturation both ways
                apply_setting($urandom_range(0, 500), $urandom_range(0, 500),
                              $urandom_range(0, 255), $urandom_range(0, 1023),
                              $urandom_range(0, 1023), $urandom_range(0, 1023),
                              $urandom_range(0, 7), $urandom_range(0, 1));
            end else begin
                low  = $urandom_range(0, 500);
                mid  = low + $urandom_range(0, 300);
                high = mid + $urandom_range(0, 300);
                if (high > 1023) high = 1023;
                apply_setting($urandom_range(low, (high < 500) ? high : 500),
                              $urandom_range(0, 500), $urandom_range(0, 255),
                              low, mid, high, $urandom_range(0, 7), $urandom_range(0, 1));
            end
            tx_calm  = (p == 2);
            rx_calm  = (p == 2);
            rx_phase = p;
            repeat (PHASE_ITEMS) send_random_item();
            idle_input();
            wait_results();
        end

        repeat (TAIL_CYCLES) @(negedge i_clk);
        run_end <= 1'b1;
        @(negedge i_clk);
        @(negedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
